FILE: rtl/fbtp_pkg.sv
// Package for the fieldbus telegram PHY controller: payload structs,
// request and event codes, telegram sizing function. No dependencies.
package fbtp_pkg;

  localparam logic [7:0] SdFixed     = 8'h10;
  localparam logic [7:0] SdVariable  = 8'h68;
  localparam logic [7:0] SdLong      = 8'hA2;
  localparam logic [7:0] SdToken     = 8'hDC;
  localparam logic [7:0] SdShortAck  = 8'hE5;

  localparam logic [7:0] LenMin      = 8'd4;
  localparam logic [7:0] LenMax      = 8'd249;
  localparam logic [7:0] SizeFixed   = 8'd6;
  localparam logic [7:0] SizeLong    = 8'd14;
  localparam logic [7:0] SizeToken   = 8'd3;
  localparam logic [7:0] SizeAck     = 8'd1;
  localparam logic [7:0] SizeVarHdr  = 8'd6;

  localparam logic [7:0] TimeoutMin  = 8'd1;
  localparam logic [7:0] TimeoutRst  = 8'd100;

  typedef enum logic [2:0] {
    REQ_START      = 3'd0,
    REQ_SLOT_FREE  = 3'd1,
    REQ_SHIFT_DONE = 3'd2,
    REQ_RX_BYTE    = 3'd3,
    REQ_MS_TICK    = 3'd4,
    REQ_ABORT      = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_ACCEPTED    = 3'd1,
    EV_REJECTED    = 3'd2,
    EV_FETCH       = 3'd3,
    EV_SENT        = 3'd4,
    EV_NOREPLY_END = 3'd5,
    EV_REPLY_DONE  = 3'd6,
    EV_REPLY_ERR   = 3'd7
  } event_e;

  typedef enum logic [1:0] {
    CFG_CHECK_ERR  = 2'd0,
    CFG_TIMEOUT    = 2'd1,
    CFG_DIR_MODE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIR_LOW        = 2'd0,
    DIR_HIGH       = 2'd1,
    DIR_HIGH_TX    = 2'd2,
    DIR_LOW_TX     = 2'd3
  } dir_mode_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] start_delim;
    logic [7:0] length_byte;
    logic [7:0] length_repeat;
    logic       want_reply;
    logic [7:0] rx_data;
    logic       rx_line_error;
  } in_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] tx_index;
    logic       rx_store;
    logic [7:0] rx_index;
    logic [7:0] reply_size;
    logic       direction_level;
    logic       activity_lamp;
    logic       receiver_on;
  } out_t;

  function automatic logic [7:0] telegram_size(input logic [7:0] sd,
                                               input logic [7:0] le,
                                               input logic [7:0] ler);
    logic [7:0] sz;
    sz = 8'd0;
    unique case (sd)
      SdFixed:    sz = SizeFixed;
      SdVariable: begin
        if (le == ler && le >= LenMin && le <= LenMax) begin
          sz = le + SizeVarHdr;
        end
      end
      SdLong:     sz = SizeLong;
      SdToken:    sz = SizeToken;
      SdShortAck: sz = SizeAck;
      default:    sz = 8'd0;
    endcase
    return sz;
  endfunction

endpackage

FILE: rtl/fieldbus_telegram_phy_controller_core.sv
// Fieldbus telegram PHY controller, top level. Depends on fbtp_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one event per
//   transaction: start, transmit slot free, shift done, received byte,
//   millisecond tick or abort. Every transaction yields exactly one result on
//   the output channel (out_valid_o / out_stall_i / out_data_o): event code,
//   transmit index, receive store strobe and index, reply size, and the
//   direction line, activity lamp and receiver enable after that event.
//   Order: a transaction is taken into the input register, and its result is
//   then registered in the result register and presented on the output.
//   Throughput: one transaction per cycle while the output is not stalled;
//   the decision logic between the two registers is a single pass over the
//   current telegram state.
//   Stall: while the result register is stalled the input register holds;
//   in_stall_o rises only when both are full, so one more transaction is
//   taken while a result waits.
//   Reset: idle, lamp off, receiver off, line-error checking on, reply
//   timeout 100 ms, direction mode always low. Configuration writes
//   (cfg_we_i, cfg_idx_i, cfg_wdata_i) are applied at once; the user must make
//   them only while no transaction is in flight, the block does not enforce it.
module fieldbus_telegram_phy_controller_core
  import fbtp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o
);

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_SEND_REPLY = 2'd1,
    PH_SEND_ONLY  = 2'd2,
    PH_RECEIVE    = 2'd3
  } phase_e;

  logic       check_err_q;
  logic [7:0] timeout_cfg_q;
  logic [1:0] dir_mode_q;

  phase_e     phase_q, phase_d;
  logic [7:0] frame_size_q, frame_size_d;
  logic [7:0] byte_pos_q, byte_pos_d;
  logic       draining_q, draining_d;
  logic [7:0] timeout_q, timeout_d;
  logic [7:0] reply_delim_q, reply_delim_d;
  logic [7:0] reply_len_q, reply_len_d;
  logic       dir_req_q, dir_req_d;

  logic       s1_valid_q;
  in_t        s1_q;
  logic       out_valid_q;
  out_t       out_q;
  out_t       res_d;

  logic       s1_adv;
  logic       in_acc;
  logic [7:0] start_size;
  logic [7:0] pos_inc;
  logic [7:0] fs_work;
  logic [7:0] tick_left;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign start_size = telegram_size(s1_q.start_delim, s1_q.length_byte, s1_q.length_repeat);
  assign pos_inc    = byte_pos_q + 8'd1;
  assign tick_left  = timeout_q - 8'd1;

  always_comb begin
    phase_d       = phase_q;
    frame_size_d  = frame_size_q;
    byte_pos_d    = byte_pos_q;
    draining_d    = draining_q;
    timeout_d     = timeout_q;
    reply_delim_d = reply_delim_q;
    reply_len_d   = reply_len_q;
    dir_req_d     = dir_req_q;
    fs_work       = frame_size_q;
    res_d         = '0;
    res_d.event_res = EV_NONE;

    unique case (s1_q.req_type)
      REQ_START: begin
        if (start_size == 8'd0 || phase_q != PH_IDLE) begin
          res_d.event_res = EV_REJECTED;
        end else begin
          phase_d         = s1_q.want_reply ? PH_SEND_REPLY : PH_SEND_ONLY;
          frame_size_d    = start_size;
          byte_pos_d      = 8'd0;
          draining_d      = 1'b0;
          dir_req_d       = 1'b1;
          res_d.event_res = EV_ACCEPTED;
        end
      end
      REQ_SLOT_FREE: begin
        if ((phase_q == PH_SEND_REPLY || phase_q == PH_SEND_ONLY) && !draining_q) begin
          if (byte_pos_q >= frame_size_q) begin
            draining_d = 1'b1;
          end else begin
            res_d.event_res = EV_FETCH;
            res_d.tx_index  = byte_pos_q;
            byte_pos_d      = pos_inc;
          end
        end
      end
      REQ_SHIFT_DONE: begin
        if (draining_q) begin
          draining_d = 1'b0;
          if (phase_q == PH_SEND_REPLY) begin
            dir_req_d       = 1'b0;
            phase_d         = PH_RECEIVE;
            frame_size_d    = 8'd0;
            byte_pos_d      = 8'd0;
            timeout_d       = (timeout_cfg_q == 8'd0) ? TimeoutMin : timeout_cfg_q;
            res_d.event_res = EV_SENT;
          end else if (phase_q == PH_SEND_ONLY) begin
            dir_req_d       = 1'b0;
            phase_d         = PH_IDLE;
            res_d.event_res = EV_NOREPLY_END;
          end
        end
      end
      REQ_RX_BYTE: begin
        if (phase_q == PH_RECEIVE) begin
          if (s1_q.rx_line_error && check_err_q) begin
            phase_d          = PH_IDLE;
            res_d.event_res  = EV_REPLY_ERR;
            res_d.reply_size = frame_size_q;
          end else begin
            res_d.rx_store = 1'b1;
            res_d.rx_index = byte_pos_q;
            byte_pos_d     = pos_inc;
            if (byte_pos_q == 8'd0) begin
              reply_delim_d = s1_q.rx_data;
            end
            if (byte_pos_q == 8'd1) begin
              reply_len_d = s1_q.rx_data;
            end
            if (pos_inc == 8'd1 && reply_delim_d != SdVariable) begin
              fs_work = telegram_size(reply_delim_d, 8'd0, 8'd0);
            end
            frame_size_d = fs_work;
            priority if (pos_inc == 8'd1 && reply_delim_d != SdVariable
                         && fs_work == 8'd0) begin
              phase_d         = PH_IDLE;
              res_d.event_res = EV_REPLY_ERR;
            end else if (fs_work != 8'd0 && pos_inc >= fs_work) begin
              phase_d          = PH_IDLE;
              res_d.event_res  = EV_REPLY_DONE;
              res_d.reply_size = fs_work;
            end else if (fs_work == 8'd0 && pos_inc == 8'd3
                         && reply_delim_q == SdVariable) begin
              frame_size_d = telegram_size(SdVariable, reply_len_q, s1_q.rx_data);
              if (frame_size_d == 8'd0) begin
                phase_d         = PH_IDLE;
                res_d.event_res = EV_REPLY_ERR;
              end
            end else begin
            end
          end
        end
      end
      REQ_MS_TICK: begin
        if (phase_q == PH_RECEIVE) begin
          timeout_d = tick_left;
          if (tick_left == 8'd0) begin
            phase_d          = PH_IDLE;
            res_d.event_res  = EV_REPLY_ERR;
            res_d.reply_size = frame_size_q;
          end
        end
      end
      REQ_ABORT: begin
        phase_d      = PH_IDLE;
        frame_size_d = 8'd0;
        byte_pos_d   = 8'd0;
        draining_d   = 1'b0;
        dir_req_d    = 1'b0;
      end
      default: begin
      end
    endcase

    unique case (dir_mode_q)
      DIR_LOW:     res_d.direction_level = 1'b0;
      DIR_HIGH:    res_d.direction_level = 1'b1;
      DIR_HIGH_TX: res_d.direction_level = dir_req_d;
      DIR_LOW_TX:  res_d.direction_level = !dir_req_d;
      default:     res_d.direction_level = 1'b0;
    endcase
    res_d.activity_lamp = (phase_d != PH_IDLE);
    res_d.receiver_on   = (phase_d == PH_RECEIVE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_err_q   <= 1'b1;
      timeout_cfg_q <= TimeoutRst;
      dir_mode_q    <= DIR_LOW;
      phase_q       <= PH_IDLE;
      frame_size_q  <= 8'd0;
      byte_pos_q    <= 8'd0;
      draining_q    <= 1'b0;
      timeout_q     <= 8'd0;
      reply_delim_q <= 8'd0;
      reply_len_q   <= 8'd0;
      dir_req_q     <= 1'b0;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (s1_adv) begin
        phase_q       <= phase_d;
        frame_size_q  <= frame_size_d;
        byte_pos_q    <= byte_pos_d;
        draining_q    <= draining_d;
        timeout_q     <= timeout_d;
        reply_delim_q <= reply_delim_d;
        reply_len_q   <= reply_len_d;
      end
      if (cfg_we_i && cfg_idx_i == CFG_DIR_MODE) begin
        dir_req_q <= 1'b0;
      end else if (s1_adv) begin
        dir_req_q <= dir_req_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CHECK_ERR: check_err_q   <= cfg_wdata_i[0];
          CFG_TIMEOUT:   timeout_cfg_q <= cfg_wdata_i;
          CFG_DIR_MODE:  dir_mode_q    <= cfg_wdata_i[1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_data_i;
    end
    if (s1_adv) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/fbtp_checker.sv
// Port-level checker for the fieldbus telegram PHY controller, with its bind.
// Depends on fbtp_pkg.
module fbtp_checker
  import fbtp_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_store_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.rx_store |->
      out_data_o.event_res == EV_NONE || out_data_o.event_res == EV_REPLY_DONE
      || out_data_o.event_res == EV_REPLY_ERR)
    else $error("receive store with unexpected event");

  a_rx_lamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.receiver_on |-> out_data_o.activity_lamp)
    else $error("receiver on while lamp off");

  a_fetch_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_res == EV_FETCH |->
      out_data_o.activity_lamp && !out_data_o.receiver_on)
    else $error("fetch outside a send phase");

  a_size_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.reply_size != 8'd0 |->
      out_data_o.event_res == EV_REPLY_DONE || out_data_o.event_res == EV_REPLY_ERR)
    else $error("reply size without reply event");

endmodule

bind fieldbus_telegram_phy_controller_core fbtp_checker u_fbtp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
